### hw/rtl/sos_pkg.sv
// ----------------------------------------------------------------------------
// sos_pkg: shared types, character codes and helpers for the operator spacer
// Holds the byte codes, the per-line state, the result record and the
// helper functions that build one group of output bytes.
// ----------------------------------------------------------------------------
package sos_pkg;

  localparam int MAX_RES = 3;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // held half operator
  localparam logic [1:0] HELD_NONE = 2'd0;
  localparam logic [1:0] HELD_AMP  = 2'd1;
  localparam logic [1:0] HELD_BAR  = 2'd2;

  // pending space after a token
  localparam logic [1:0] PEND_NONE  = 2'd0;
  localparam logic [1:0] PEND_PAREN = 2'd1;
  localparam logic [1:0] PEND_OP    = 2'd2;

  typedef struct packed {
    logic       quote_open;
    logic       any_emitted;
    logic       last_was_space;
    logic [1:0] held_half_op;
    logic [1:0] space_after_pending;
  } line_state_t;

  // one group of output bytes built for one input word
  typedef struct packed {
    logic [MAX_RES-1:0][7:0] slot;
    logic [1:0]              cnt;
    logic                    any_emitted;
    logic                    last_was_space;
  } acc_t;

  typedef struct packed {
    logic [MAX_RES-1:0][7:0] slot;
    logic [1:0]              cnt;
    logic                    fin;
  } res_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic acc_t put_byte(input acc_t a, input logic [7:0] b);
    acc_t r;
    r = a;
    if (a.cnt < 2'(MAX_RES)) begin
      r.slot[a.cnt] = b;
      r.cnt         = a.cnt + 2'd1;
    end
    r.any_emitted    = 1'b1;
    r.last_was_space = (b == CH_SPACE);
    return r;
  endfunction

  function automatic acc_t space_before(input acc_t a);
    acc_t r;
    r = a;
    if (a.any_emitted && !a.last_was_space) begin
      r = put_byte(a, CH_SPACE);
    end
    return r;
  endfunction

  function automatic logic [7:0] held_char(input logic [1:0] h);
    return (h == HELD_AMP) ? CH_AMP : CH_BAR;
  endfunction

endpackage

### hw/rtl/sos_expand.sv
// ----------------------------------------------------------------------------
// sos_expand: line state and byte expansion
// Turns one registered input word into up to three output bytes and
// advances the per-line state when the word is taken.
// ----------------------------------------------------------------------------
module sos_expand (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        in_byte,
  input  logic              is_final,
  output sos_pkg::res_t     res
);

  sos_pkg::line_state_t state;
  sos_pkg::line_state_t state_next;

  always_comb begin
    sos_pkg::acc_t acc;
    logic          quote;
    logic [1:0]    held;
    logic [1:0]    pend;
    logic          add;
    logic          take;
    logic [7:0]    hc;

    acc                = '0;
    acc.any_emitted    = state.any_emitted;
    acc.last_was_space = state.last_was_space;
    quote              = state.quote_open;
    held               = state.held_half_op;
    pend               = state.space_after_pending;
    take               = 1'b1;
    add                = 1'b0;
    hc                 = sos_pkg::held_char(held);

    // resolve a space owed to the previous token
    if (pend != sos_pkg::PEND_NONE) begin
      add  = (pend == sos_pkg::PEND_PAREN) ? (in_byte != sos_pkg::CH_SPACE)
                                           : !sos_pkg::is_ws(in_byte);
      pend = sos_pkg::PEND_NONE;
      if (add) begin
        acc = sos_pkg::put_byte(acc, sos_pkg::CH_SPACE);
      end
    end

    if (held != sos_pkg::HELD_NONE) begin
      held = sos_pkg::HELD_NONE;
      if (in_byte == hc) begin
        acc  = sos_pkg::space_before(acc);
        acc  = sos_pkg::put_byte(acc, hc);
        acc  = sos_pkg::put_byte(acc, hc);
        pend = sos_pkg::PEND_OP;
        take = 1'b0;
      end else begin
        acc = sos_pkg::put_byte(acc, hc);
      end
    end

    if (take) begin
      if (!quote && (in_byte == sos_pkg::CH_LPAREN || in_byte == sos_pkg::CH_RPAREN)) begin
        acc  = sos_pkg::space_before(acc);
        acc  = sos_pkg::put_byte(acc, in_byte);
        pend = sos_pkg::PEND_PAREN;
      end else if (!quote && (in_byte == sos_pkg::CH_AMP || in_byte == sos_pkg::CH_BAR)) begin
        held = (in_byte == sos_pkg::CH_AMP) ? sos_pkg::HELD_AMP : sos_pkg::HELD_BAR;
      end else begin
        if (in_byte == sos_pkg::CH_DQUOTE || in_byte == sos_pkg::CH_SQUOTE) begin
          quote = !quote;
        end
        acc = sos_pkg::put_byte(acc, in_byte);
      end
    end

    // line end: flush a held half operator and start a fresh line
    if (is_final && held != sos_pkg::HELD_NONE) begin
      acc = sos_pkg::put_byte(acc, sos_pkg::held_char(held));
    end

    res.slot = acc.slot;
    res.cnt  = acc.cnt;
    res.fin  = is_final;

    if (is_final) begin
      state_next = '0;
    end else begin
      state_next.quote_open          = quote;
      state_next.any_emitted         = acc.any_emitted;
      state_next.last_was_space      = acc.last_was_space;
      state_next.held_half_op        = held;
      state_next.space_after_pending = pend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (step) begin
      state <= state_next;
    end
  end

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    (step && is_final) |=> (state == '0))
    else $error("line state not cleared after final word");

  a_held_pend_excl: assert property (@(posedge clk) disable iff (rst)
    !((state.held_half_op != sos_pkg::HELD_NONE) &&
      (state.space_after_pending != sos_pkg::PEND_NONE)))
    else $error("held operator and pending space both set");

endmodule

### hw/rtl/sos_serializer.sv
// ----------------------------------------------------------------------------
// sos_serializer: result buffer and output drain
// Holds one group of up to three bytes; drains one per cycle when out_ready.
// ----------------------------------------------------------------------------
module sos_serializer (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  sos_pkg::res_t res,
  output logic          load_ok,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          out_final
);

  logic [sos_pkg::MAX_RES-1:0][7:0] slot;
  logic [1:0]                       cnt;
  logic                             fin;
  logic                             drain;

  assign out_valid = (cnt != 2'd0);
  assign out_byte  = slot[0];
  assign out_final = fin && (cnt == 2'd1);
  assign drain     = out_valid && out_ready;
  // buffer frees this cycle if empty or its last byte leaves now
  assign load_ok   = (cnt == 2'd0) || ((cnt == 2'd1) && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= res.cnt;
    end else if (drain) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot <= res.slot;
      fin  <= res.fin;
    end else if (drain) begin
      slot[0] <= slot[1];
      slot[1] <= slot[2];
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> ((cnt == 2'd0) || ((cnt == 2'd1) && out_ready)))
    else $error("result buffer overwritten while bytes remain");

  a_more_bytes: assert property (@(posedge clk) disable iff (rst)
    (drain && cnt > 2'd1) |=> out_valid)
    else $error("bytes of a group lost");

endmodule

### hw/rtl/shell_operator_spacer.sv
// ----------------------------------------------------------------------------
// shell_operator_spacer: spaces out parens, && and || in a command line
// Registers each input word, expands it into up to three output bytes
// and drains those bytes one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
// channel | signals                          | direction
// in      | in_valid in_ready in_byte is_final | into block
// out     | out_valid out_ready out_byte out_final | out of block
//
// The single output port drains the three-byte result buffer one byte at a
// time; a new word's group loads only when the buffer is empty or its last
// byte is leaving.
// Reset (rst, synchronous) clears the line state and both buffers.
// An output stall holds the buffered group; the input register takes one
// more word and then in_ready drops until the buffer frees.
// ----------------------------------------------------------------------------
module shell_operator_spacer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       is_final,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_final
);

  logic          in_full;
  logic [7:0]    byte_q;
  logic          final_q;
  logic          load_ok;
  logic          step;
  sos_pkg::res_t res;

  assign step     = in_full && load_ok;
  assign in_ready = !in_full || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q  <= in_byte;
      final_q <= is_final;
    end
  end

  sos_expand u_expand (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .in_byte  (byte_q),
    .is_final (final_q),
    .res      (res)
  );

  sos_serializer u_serializer (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .res       (res),
    .load_ok   (load_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_final (out_final)
  );

endmodule

### tb/tb_shell_operator_spacer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_shell_operator_spacer: self-checking bench for the operator spacer
// Feeds command lines one word at a time, first a short directed set and
// then random lines, while predicting the spaced output in the bench itself.
// Every output word is compared against the oldest predicted byte.
// ----------------------------------------------------------------------------
module tb_shell_operator_spacer;

  localparam int TOTAL_WORDS = 270;
  localparam int QUIET_LIMIT = 2000;
  localparam int IDLE_PCT    = 36;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } cmd_word_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } spaced_char_t;

  logic       clk       = 1'b0;
  logic       rst;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte   = 8'h00;
  logic       is_final  = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_final;

  cmd_word_t    line_feed_q [$];
  spaced_char_t spaced_q [$];

  int  words_queued = 0;
  int  words_taken  = 0;
  int  chars_seen   = 0;
  int  errors       = 0;
  int  quiet        = 0;
  int  rx_hold_left = 0;
  bit  rx_hold_done = 0;
  bit  took_in      = 0;
  logic calm;

  // predicted line state
  logic       p_quote;
  logic       p_emitted;
  logic       p_last_sp;
  logic [1:0] p_held;
  logic [1:0] p_pend;
  logic [7:0] grp [sos_pkg::MAX_RES];
  int         grp_n;

  shell_operator_spacer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .is_final  (is_final),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_final (out_final)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // no idling on either side through this window of the run
  assign calm = (words_taken >= 150) && (words_taken < 210);

  task automatic clear_line();
    p_quote   = 1'b0;
    p_emitted = 1'b0;
    p_last_sp = 1'b0;
    p_held    = sos_pkg::HELD_NONE;
    p_pend    = sos_pkg::PEND_NONE;
  endtask

  task automatic emit_char(input logic [7:0] b);
    if (grp_n < sos_pkg::MAX_RES) begin
      grp[grp_n] = b;
      grp_n++;
    end
    p_emitted = 1'b1;
    p_last_sp = (b == sos_pkg::CH_SPACE);
  endtask

  task automatic space_before_tok();
    if (p_emitted && !p_last_sp) begin
      emit_char(sos_pkg::CH_SPACE);
    end
  endtask

  task automatic consume_char(input logic [7:0] b);
    if (!p_quote && (b == sos_pkg::CH_LPAREN || b == sos_pkg::CH_RPAREN)) begin
      space_before_tok();
      emit_char(b);
      p_pend = sos_pkg::PEND_PAREN;
    end else if (!p_quote && (b == sos_pkg::CH_AMP || b == sos_pkg::CH_BAR)) begin
      p_held = (b == sos_pkg::CH_AMP) ? sos_pkg::HELD_AMP : sos_pkg::HELD_BAR;
    end else begin
      if (b == sos_pkg::CH_DQUOTE || b == sos_pkg::CH_SQUOTE) begin
        p_quote = !p_quote;
      end
      emit_char(b);
    end
  endtask

  task automatic space_out_word(input logic [7:0] b, input logic fin);
    logic [7:0]   hc;
    logic         add;
    spaced_char_t s;
    grp_n = 0;
    if (p_pend != sos_pkg::PEND_NONE) begin
      if (p_pend == sos_pkg::PEND_PAREN) begin
        add = (b != sos_pkg::CH_SPACE);
      end else begin
        add = !((b == sos_pkg::CH_SPACE) || (b >= sos_pkg::CH_TAB && b <= sos_pkg::CH_CR));
      end
      p_pend = sos_pkg::PEND_NONE;
      if (add) begin
        emit_char(sos_pkg::CH_SPACE);
      end
    end
    if (p_held != sos_pkg::HELD_NONE) begin
      hc = (p_held == sos_pkg::HELD_AMP) ? sos_pkg::CH_AMP : sos_pkg::CH_BAR;
      p_held = sos_pkg::HELD_NONE;
      if (b == hc) begin
        space_before_tok();
        emit_char(hc);
        emit_char(hc);
        p_pend = sos_pkg::PEND_OP;
      end else begin
        emit_char(hc);
        consume_char(b);
      end
    end else begin
      consume_char(b);
    end
    if (fin) begin
      // flush a held half operator, drop any pending space
      if (p_held != sos_pkg::HELD_NONE) begin
        emit_char((p_held == sos_pkg::HELD_AMP) ? sos_pkg::CH_AMP : sos_pkg::CH_BAR);
      end
      clear_line();
    end
    for (int i = 0; i < grp_n; i++) begin
      s.ch  = grp[i];
      s.fin = fin && (i == grp_n - 1);
      spaced_q.push_back(s);
    end
  endtask

  task automatic queue_word(input logic [7:0] b, input logic fin);
    cmd_word_t w;
    w.ch  = b;
    w.fin = fin;
    line_feed_q.push_back(w);
    words_queued++;
  endtask

  task automatic queue_line(input string s);
    for (int i = 0; i < s.len(); i++) begin
      queue_word(s[i], i == s.len() - 1);
    end
  endtask

  task automatic queue_random_line();
    logic [7:0] buf_q [$];
    int         len;
    int         r;
    len = $urandom_range(1, 12);
    while (buf_q.size() < len) begin
      r = $urandom_range(99);
      if (r < 20) begin
        buf_q.push_back(($urandom_range(1) == 1) ? sos_pkg::CH_AMP : sos_pkg::CH_BAR);
        buf_q.push_back(buf_q[buf_q.size() - 1]);
      end else if (r < 35) begin
        buf_q.push_back(($urandom_range(1) == 1) ? sos_pkg::CH_LPAREN : sos_pkg::CH_RPAREN);
      end else if (r < 42) begin
        buf_q.push_back(($urandom_range(1) == 1) ? sos_pkg::CH_DQUOTE : sos_pkg::CH_SQUOTE);
      end else if (r < 52) begin
        buf_q.push_back(sos_pkg::CH_SPACE);
      end else if (r < 56) begin
        buf_q.push_back(8'($urandom_range(9, 13)));
      end else if (r < 62) begin
        buf_q.push_back(($urandom_range(1) == 1) ? sos_pkg::CH_AMP : sos_pkg::CH_BAR);
      end else begin
        buf_q.push_back(8'($urandom_range(1, 255)));
      end
    end
    foreach (buf_q[i]) begin
      queue_word(buf_q[i], i == buf_q.size() - 1);
    end
  endtask

  // driver: present the next word on the falling edge
  always @(negedge clk) begin
    cmd_word_t w;
    bit        go;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || took_in) begin
      go = (line_feed_q.size() > 0) &&
           (calm || rx_hold_left > 0 || $urandom_range(99) >= IDLE_PCT);
      if (go) begin
        w = line_feed_q.pop_front();
        in_valid <= 1'b1;
        in_byte  <= w.ch;
        is_final <= w.fin;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random backpressure plus one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_ready    <= 1'b0;
    end else if (!rx_hold_done && chars_seen >= 80) begin
      rx_hold_left <= 60;
      rx_hold_done <= 1'b1;
      out_ready    <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // monitor: check outputs, then predict for the word taken at this edge
  always @(posedge clk) begin
    spaced_char_t e;
    bit           took_out;
    took_out = !rst && out_valid && out_ready;
    took_in  = !rst && in_valid && in_ready;
    if (took_out) begin
      chars_seen++;
      if (spaced_q.size() == 0) begin
        $error("out_byte %02h arrived with nothing expected", out_byte);
        errors++;
      end else begin
        e = spaced_q.pop_front();
        if (out_byte !== e.ch) begin
          $error("out_byte mismatch: expected %02h, got %02h", e.ch, out_byte);
          errors++;
        end
        if (out_final !== e.fin) begin
          $error("out_final mismatch: expected %0b, got %0b", e.fin, out_final);
          errors++;
        end
      end
    end
    if (took_in) begin
      space_out_word(in_byte, is_final);
      words_taken++;
    end
    if (took_in || took_out) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    clear_line();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    queue_line("(a)");
    queue_line("x&&y");
    queue_line("&&&");
    queue_line("'|'|");
    queue_line("\"(\"");
    queue_line("||\t");
    queue_word(8'h01, 1'b0);
    queue_word(sos_pkg::CH_SPACE, 1'b0);
    queue_word(sos_pkg::CH_LPAREN, 1'b0);
    queue_word(8'hFF, 1'b1);
    queue_line("&");

    // pause the sender until the directed lines have fully drained
    while (!(words_taken == words_queued && spaced_q.size() == 0)) @(negedge clk);

    while (words_queued < TOTAL_WORDS) begin
      queue_random_line();
    end

    while (!(words_taken == words_queued && spaced_q.size() == 0)) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0 && spaced_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
